[hdl/fld_pkg.sv]
// shared types and constants for the file-list deframer
// no dependencies; imported by every module of the block
package fld_pkg;

    localparam int SIZE_W  = 20;
    localparam int MAXL_W  = 13;
    localparam int COUNT_W = 18;
    localparam int LEN_W   = 32;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [SIZE_W-1:0] SIZE_RESET = 20'd8;
    localparam logic [MAXL_W-1:0] MAXL_RESET = 13'd4096;
    localparam logic [SIZE_W-1:0] HEADER_LEN = 20'd8;

    // configuration register indexes
    localparam logic REG_BUFFER_SIZE  = 1'b0;
    localparam logic REG_MAX_NAME_LEN = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_NAME  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_NAME,
        PH_SKIP,
        PH_SWALLOW
    } phase_t;

    // what one input byte produced: an optional name byte, then an optional end result
    typedef struct packed {
        logic               has_name;
        logic [7:0]         name_byte;
        logic               has_end;
        logic               end_err;
        logic [COUNT_W-1:0] count;
    } rec_t;

endpackage

[hdl/file_list_deframer_top.sv]
// Parses a file-list buffer one byte per cycle: s_tready stays high while the four-record
// queue behind the parser has room, so bytes stream in back to back. The parser registers
// its offset, header and length counters as each byte is accepted. A byte that yields two
// results (the first entry's last name byte, also the final byte) is split into two at the
// output register, which the queue absorbs. Results: tuser 0 name byte of the first entry,
// 1 done with entry_count, 2 error; tlast marks the done or error result ending a buffer.
// Configuration writes (index 0 buffer_size, 1 max_name_len) belong between buffers.
// depends on fld_pkg, fld_front, fld_queue, fld_back
module file_list_deframer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [19:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [7:0] name_byte, [25:8] entry_count, [31:26] zero
    output logic [1:0]  m_tuser,    // [1:0] kind
    output logic        m_tlast
);
    import fld_pkg::*;

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    rec_t push_rec;
    rec_t pop_rec;

    fld_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_rec     (push_rec)
    );

    fld_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_rec (push_rec),
        .pop      (q_pop),
        .pop_rec  (pop_rec),
        .full     (q_full),
        .empty    (q_empty)
    );

    fld_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_rec    (pop_rec),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[hdl/fld_front.sv]
// front end: configuration registers and the per-byte buffer parser
// depends on fld_pkg; pushes result records into fld_queue
module fld_front (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [19:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,     // [7:0] data_byte
    input  logic         q_full,
    output logic         q_push,
    output fld_pkg::rec_t q_rec
);
    import fld_pkg::*;

    logic [SIZE_W-1:0]  size_reg;
    logic [MAXL_W-1:0]  maxl_reg;
    logic [SIZE_W-1:0]  offset_reg,  offset_next;
    phase_t             phase_reg,   phase_next;
    logic [2:0]         hpos_reg,    hpos_next;
    logic [LEN_W-1:0]   acc_reg,     acc_next;
    logic [MAXL_W-1:0]  nleft_reg,   nleft_next;
    logic [COUNT_W-1:0] entries_reg, entries_next;

    logic               accept;
    logic               final_byte;
    logic               hdr_fits;
    logic               err;
    logic [SIZE_W:0]    off_plus1;
    logic [SIZE_W:0]    off_plus8;
    logic [SIZE_W:0]    size_ext;
    logic [SIZE_W:0]    left;
    logic [LEN_W-1:0]   acc_val;
    rec_t               rec;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;

    assign size_ext   = {1'b0, size_reg};
    assign off_plus1  = {1'b0, offset_reg} + 21'd1;
    assign off_plus8  = {1'b0, offset_reg} + {1'b0, HEADER_LEN};
    assign final_byte = off_plus1 >= size_ext;
    assign hdr_fits   = off_plus8 < size_ext;
    assign left       = final_byte ? '0 : (size_ext - off_plus1);
    assign acc_val    = hpos_reg[2] ? {acc_reg[LEN_W-9:0], s_tdata} : acc_reg;

    always_comb begin
        offset_next  = offset_reg;
        phase_next   = phase_reg;
        hpos_next    = hpos_reg;
        acc_next     = acc_reg;
        nleft_next   = nleft_reg;
        entries_next = entries_reg;
        err          = 1'b0;
        rec          = '0;

        if (phase_reg == PH_HEADER && hpos_reg == 3'd0 && offset_reg == '0
            && size_reg < HEADER_LEN) begin
            err = 1'b1;
        end else begin
            unique case (phase_reg)
                PH_HEADER: begin
                    if (hpos_reg == 3'd0 && !hdr_fits) begin
                        phase_next = PH_SKIP;
                    end else begin
                        acc_next  = acc_val;
                        hpos_next = hpos_reg + 3'd1;
                        if (hpos_reg == 3'd7) begin
                            if (acc_val > {{(LEN_W-SIZE_W-1){1'b0}}, left}
                                || acc_val > {{(LEN_W-MAXL_W){1'b0}}, maxl_reg}) begin
                                err = 1'b1;
                            end else if (acc_val == '0) begin
                                entries_next = entries_reg + 1'b1;
                                phase_next   = PH_HEADER;
                                acc_next     = '0;
                                nleft_next   = '0;
                            end else begin
                                nleft_next = acc_val[MAXL_W-1:0];
                                acc_next   = '0;
                                phase_next = PH_NAME;
                            end
                        end
                    end
                end
                PH_NAME: begin
                    // only the first entry's name goes out
                    if (entries_reg == '0) begin
                        rec.has_name  = 1'b1;
                        rec.name_byte = s_tdata;
                    end
                    nleft_next = nleft_reg - 1'b1;
                    if (nleft_next == '0) begin
                        entries_next = entries_reg + 1'b1;
                        phase_next   = PH_HEADER;
                        hpos_next    = 3'd0;
                        acc_next     = '0;
                    end
                end
                PH_SKIP, PH_SWALLOW: begin
                end
                default: begin
                end
            endcase
        end

        if (err) begin
            rec.has_end = 1'b1;
            rec.end_err = 1'b1;
            if (final_byte) begin
                offset_next = '0;
                phase_next  = PH_HEADER;
                hpos_next   = 3'd0;
                acc_next    = '0;
                nleft_next  = '0;
                entries_next = '0;
            end else begin
                phase_next  = PH_SWALLOW;
                offset_next = off_plus1[SIZE_W-1:0];
            end
        end else if (final_byte) begin
            if (phase_next != PH_SWALLOW) begin
                rec.has_end = 1'b1;
                rec.count   = entries_next;
            end
            offset_next  = '0;
            phase_next   = PH_HEADER;
            hpos_next    = 3'd0;
            acc_next     = '0;
            nleft_next   = '0;
            entries_next = '0;
        end else begin
            offset_next = off_plus1[SIZE_W-1:0];
        end
    end

    assign q_push = accept && (rec.has_name || rec.has_end);
    assign q_rec  = rec;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= SIZE_RESET;
            maxl_reg <= MAXL_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_BUFFER_SIZE:  size_reg <= cfg_data;
                REG_MAX_NAME_LEN: maxl_reg <= cfg_data[MAXL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg  <= '0;
            phase_reg   <= PH_HEADER;
            hpos_reg    <= 3'd0;
            acc_reg     <= '0;
            nleft_reg   <= '0;
            entries_reg <= '0;
        end else if (accept) begin
            offset_reg  <= offset_next;
            phase_reg   <= phase_next;
            hpos_reg    <= hpos_next;
            acc_reg     <= acc_next;
            nleft_reg   <= nleft_next;
            entries_reg <= entries_next;
        end
    end

endmodule

[hdl/fld_queue.sv]
// small record queue between the parser and the output stage
// depends on fld_pkg
module fld_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  fld_pkg::rec_t push_rec,
    input  logic          pop,
    output fld_pkg::rec_t pop_rec,
    output logic          full,
    output logic          empty
);
    import fld_pkg::*;

    rec_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    localparam logic [QPTR_W:0] DEPTH_CNT = QUEUE_DEPTH[QPTR_W:0];

    assign full    = count_reg == DEPTH_CNT;
    assign empty   = count_reg == '0;
    assign pop_rec = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("record pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty))
        else $error("record popped from an empty queue");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_CNT)
        else $error("queue fill count out of range");

    a_push_only_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue fill count did not follow a lone push");

endmodule

[hdl/fld_back.sv]
// back end: splits each record into one or two result requests on the output register
// depends on fld_pkg; pops records from fld_queue
module fld_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_empty,
    input  fld_pkg::rec_t q_rec,
    output logic          q_pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [31:0]   m_tdata,    // [7:0] name_byte, [25:8] entry_count, [31:26] zero
    output logic [1:0]    m_tuser,    // [1:0] kind
    output logic          m_tlast
);
    import fld_pkg::*;

    logic               valid_reg;
    logic [1:0]         kind_reg;
    logic [7:0]         name_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               last_reg;

    // end result still owed by the record already popped
    logic               pend_reg;
    logic               pend_err_reg;
    logic [COUNT_W-1:0] pend_count_reg;

    logic load;

    assign load  = !valid_reg || m_tready;
    assign q_pop = load && !pend_reg && !q_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end else if (load) begin
            if (pend_reg) begin
                valid_reg <= 1'b1;
                pend_reg  <= 1'b0;
            end else if (!q_empty) begin
                valid_reg <= 1'b1;
                pend_reg  <= q_rec.has_name && q_rec.has_end;
            end else begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            if (pend_reg) begin
                kind_reg  <= pend_err_reg ? KIND_ERROR : KIND_DONE;
                name_reg  <= '0;
                count_reg <= pend_count_reg;
                last_reg  <= 1'b1;
            end else if (!q_empty) begin
                pend_err_reg   <= q_rec.end_err;
                pend_count_reg <= q_rec.count;
                if (q_rec.has_name) begin
                    kind_reg  <= KIND_NAME;
                    name_reg  <= q_rec.name_byte;
                    count_reg <= '0;
                    last_reg  <= 1'b0;
                end else begin
                    kind_reg  <= q_rec.end_err ? KIND_ERROR : KIND_DONE;
                    name_reg  <= '0;
                    count_reg <= q_rec.count;
                    last_reg  <= 1'b1;
                end
            end
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'd0, count_reg, name_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule
